FILE: rtl/core/record_comment_stripper_core_defines.svh
// Assertion macros shared by the record comment stripper RTL.
`ifndef RECORD_COMMENT_STRIPPER_CORE_DEFINES_SVH
`define RECORD_COMMENT_STRIPPER_CORE_DEFINES_SVH

// Clocked assertion, quiet while reset is asserted.
`define RCS_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check with a fixed generic message.
`define RCS_ASSERT(name, prop) \
  `RCS_ASSERT_MSG(name, prop, "record stripper check failed")

`endif

FILE: rtl/core/rcs_pkg.sv
// Types and constants of the record comment stripper.
`default_nettype none
package rcs_pkg;

  // Scanner mode
  typedef enum logic [3:0] {
    MODE_START      = 4'd0,
    MODE_NORMAL     = 4'd1,
    MODE_SLASH      = 4'd2,
    MODE_LINE       = 4'd3,
    MODE_BLOCK      = 4'd4,
    MODE_BLOCK_STAR = 4'd5,
    MODE_AFTER_BLK  = 4'd6,
    MODE_STRING     = 4'd7,
    MODE_STRING_ESC = 4'd8,
    MODE_NL_PEND    = 4'd9
  } mode_e;

  // Result word kind
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // Error codes
  localparam logic [1:0] ERR_BLANK_CONT   = 2'd0;
  localparam logic [1:0] ERR_BLOCK_OPEN   = 2'd1;
  localparam logic [1:0] ERR_EOS_STRING   = 2'd2;
  localparam logic [1:0] ERR_NL_STRING    = 2'd3;

  // Characters
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  // Result queue geometry
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Scanner state
  typedef struct packed {
    mode_e mode;
    logic  quote_single;
    logic  blank;
    logic  halted;
  } state_t;

  // One result word
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       blank;
    logic [1:0] code;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/record_comment_stripper_core.sv
// Record comment stripper: top level with scanner state and result queue.
//
// Takes one text byte (or an end-of-stream word) per cycle while in_ready_o is
// high and returns record bytes, end-of-record marks with a blank flag, and
// error reports, in stream order. Comments outside quoted strings are dropped
// and '+' continuation lines are joined. Each input word is scanned in the
// cycle it is accepted and produces zero, one or two result words, which enter
// a four-word result queue; the output side drains one word per cycle while
// out_ready_i is high. in_ready_o stays high while the queue has room for two
// more words, so with an output side that takes every cycle a new byte is
// accepted every cycle; results pass through the queue registers. After an
// error report the block drops all further input until reset.
`default_nettype none
`include "record_comment_stripper_core_defines.svh"
module record_comment_stripper_core import rcs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       func_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic       record_blank_o,
  output logic [1:0] error_code_o,
  output logic       last_o
);

  state_t           state_q, state_d;
  logic [1:0]       push_cnt, step_cnt;
  result_t          res0, res1, head;
  logic             head_valid, in_fire, pop;
  logic [OQ_CW-1:0] q_count;

  assign in_ready_o = (q_count <= OQ_CW'(OQ_DEPTH - 2));
  assign in_fire    = in_valid_i && in_ready_o;
  assign pop        = head_valid && out_ready_i;

  // Scan the incoming word
  rcs_step u_step (
    .cur_i      (state_q),
    .func_i     (func_i),
    .in_byte_i  (in_byte_i),
    .nxt_o      (state_d),
    .push_cnt_o (step_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  assign push_cnt = in_fire ? step_cnt : 2'd0;

  // Hold scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode         <= MODE_START;
      state_q.quote_single <= 1'b0;
      state_q.blank        <= 1'b1;
      state_q.halted       <= 1'b0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Queue results for the output side
  rcs_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cnt_i   (push_cnt),
    .push0_i      (res0),
    .push1_i      (res1),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .count_o      (q_count)
  );

  assign out_valid_o    = head_valid;
  assign kind_o         = head.kind;
  assign out_byte_o     = head.data;
  assign record_blank_o = head.blank;
  assign error_code_o   = head.code;
  assign last_o         = head.last;

  `RCS_ASSERT_MSG(a_halt_sticky, state_q.halted |=> state_q.halted, "halt flag cleared")
  `RCS_ASSERT_MSG(a_halt_silent, (in_fire && state_q.halted) |-> (push_cnt == 2'd0),
                  "results produced while halted")
  `RCS_ASSERT_MSG(a_err_halts,
                  (in_fire && step_cnt != 2'd0 && res0.kind == KIND_ERR) |=> state_q.halted,
                  "error without halt")
  `RCS_ASSERT(a_q_bound, q_count <= OQ_CW'(OQ_DEPTH))
  `RCS_ASSERT(a_pair_ends, (in_fire && step_cnt == 2'd2) |-> (res1.last && !res0.last))

endmodule
`default_nettype wire

FILE: rtl/core/rcs_step.sv
// Per-word scanner update: next state and up to two result words.
`default_nettype none
module rcs_step import rcs_pkg::*; (
  input  state_t      cur_i,
  input  logic        func_i,
  input  logic [7:0]  in_byte_i,
  output state_t      nxt_o,
  output logic [1:0]  push_cnt_o,
  output result_t     res0_o,
  output result_t     res1_o
);

  typedef struct packed {
    logic  emit;
    mode_e mode;
    logic  blank;
    logic  quote_single;
  } plain_t;

  // Handle a byte of plain text
  function automatic plain_t plain_byte(logic [7:0] c, logic comments, logic blank,
                                        logic quote_single);
    plain_t p;
    p.emit         = 1'b0;
    p.mode         = MODE_NORMAL;
    p.blank        = blank;
    p.quote_single = quote_single;
    if (comments && c == CH_SLASH) begin
      p.mode = MODE_SLASH;
    end else if (c == CH_NL) begin
      p.mode = MODE_NL_PEND;
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      p.emit         = 1'b1;
      p.blank        = 1'b0;
      p.quote_single = (c == CH_SQUOTE);
      p.mode         = MODE_STRING;
    end else begin
      p.emit = 1'b1;
      if (!(c inside {[8'd9:8'd13], 8'd32})) p.blank = 1'b0;
    end
    return p;
  endfunction

  function automatic result_t mk_res(kind_e kind, logic [7:0] data, logic blank,
                                     logic [1:0] code);
    result_t r;
    r.kind  = kind;
    r.data  = data;
    r.blank = blank;
    r.code  = code;
    r.last  = 1'b0;
    return r;
  endfunction

  // Scan one word
  always_comb begin
    plain_t     p;
    logic [7:0] quote_ch;
    nxt_o      = cur_i;
    push_cnt_o = 2'd0;
    res0_o     = '0;
    res1_o     = '0;
    p          = '0;
    quote_ch   = cur_i.quote_single ? CH_SQUOTE : CH_DQUOTE;
    if (cur_i.halted) begin
      nxt_o = cur_i;
    end else if (func_i) begin
      // End of stream: flush, close or fail
      case (cur_i.mode)
        MODE_START: begin
          push_cnt_o = 2'd0;
        end
        MODE_SLASH: begin
          res0_o     = mk_res(KIND_BYTE, CH_SLASH, 1'b0, 2'd0);
          res1_o     = mk_res(KIND_END, 8'd0, 1'b0, 2'd0);
          push_cnt_o = 2'd2;
        end
        MODE_BLOCK, MODE_BLOCK_STAR: begin
          res0_o       = mk_res(KIND_ERR, 8'd0, 1'b0, ERR_BLOCK_OPEN);
          push_cnt_o   = 2'd1;
          nxt_o.halted = 1'b1;
        end
        MODE_STRING, MODE_STRING_ESC: begin
          res0_o       = mk_res(KIND_ERR, 8'd0, 1'b0, ERR_EOS_STRING);
          push_cnt_o   = 2'd1;
          nxt_o.halted = 1'b1;
        end
        default: begin
          res0_o     = mk_res(KIND_END, 8'd0, cur_i.blank, 2'd0);
          push_cnt_o = 2'd1;
        end
      endcase
      if (!nxt_o.halted) begin
        nxt_o.mode  = MODE_START;
        nxt_o.blank = 1'b1;
      end
    end else begin
      case (cur_i.mode)
        MODE_SLASH: begin
          if (in_byte_i == CH_SLASH) begin
            nxt_o.mode = MODE_LINE;
          end else if (in_byte_i == CH_STAR) begin
            nxt_o.mode = MODE_BLOCK;
          end else begin
            // Held slash was plain text after all
            p                  = plain_byte(in_byte_i, 1'b1, 1'b0, cur_i.quote_single);
            res0_o             = mk_res(KIND_BYTE, CH_SLASH, 1'b0, 2'd0);
            res1_o             = mk_res(KIND_BYTE, in_byte_i, 1'b0, 2'd0);
            push_cnt_o         = p.emit ? 2'd2 : 2'd1;
            nxt_o.mode         = p.mode;
            nxt_o.blank        = p.blank;
            nxt_o.quote_single = p.quote_single;
          end
        end
        MODE_LINE: begin
          if (in_byte_i == CH_NL) nxt_o.mode = MODE_NL_PEND;
        end
        MODE_BLOCK: begin
          if (in_byte_i == CH_STAR) nxt_o.mode = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (in_byte_i == CH_SLASH) begin
            nxt_o.mode = MODE_AFTER_BLK;
          end else if (in_byte_i != CH_STAR) begin
            nxt_o.mode = MODE_BLOCK;
          end
        end
        MODE_AFTER_BLK: begin
          // No comment start right after a closed block comment
          p                  = plain_byte(in_byte_i, 1'b0, cur_i.blank, cur_i.quote_single);
          res0_o             = mk_res(KIND_BYTE, in_byte_i, 1'b0, 2'd0);
          push_cnt_o         = p.emit ? 2'd1 : 2'd0;
          nxt_o.mode         = p.mode;
          nxt_o.blank        = p.blank;
          nxt_o.quote_single = p.quote_single;
        end
        MODE_STRING: begin
          if (in_byte_i == CH_NL) begin
            res0_o       = mk_res(KIND_ERR, 8'd0, 1'b0, ERR_NL_STRING);
            push_cnt_o   = 2'd1;
            nxt_o.halted = 1'b1;
          end else begin
            res0_o     = mk_res(KIND_BYTE, in_byte_i, 1'b0, 2'd0);
            push_cnt_o = 2'd1;
            if (in_byte_i == quote_ch) begin
              nxt_o.mode = MODE_NORMAL;
            end else if (in_byte_i == CH_BSLASH) begin
              nxt_o.mode = MODE_STRING_ESC;
            end
          end
        end
        MODE_STRING_ESC: begin
          res0_o     = mk_res(KIND_BYTE, in_byte_i, 1'b0, 2'd0);
          push_cnt_o = 2'd1;
          nxt_o.mode = MODE_STRING;
        end
        MODE_NL_PEND: begin
          if (in_byte_i == CH_PLUS) begin
            // Continuation of the current record
            if (cur_i.blank) begin
              res0_o       = mk_res(KIND_ERR, 8'd0, 1'b0, ERR_BLANK_CONT);
              push_cnt_o   = 2'd1;
              nxt_o.halted = 1'b1;
            end else begin
              nxt_o.mode = MODE_NORMAL;
            end
          end else begin
            // Close the record, then scan the byte from record start
            p                  = plain_byte(in_byte_i, 1'b1, 1'b1, cur_i.quote_single);
            res0_o             = mk_res(KIND_END, 8'd0, cur_i.blank, 2'd0);
            res1_o             = mk_res(KIND_BYTE, in_byte_i, 1'b0, 2'd0);
            push_cnt_o         = p.emit ? 2'd2 : 2'd1;
            nxt_o.mode         = p.mode;
            nxt_o.blank        = p.blank;
            nxt_o.quote_single = p.quote_single;
          end
        end
        default: begin
          p                  = plain_byte(in_byte_i, 1'b1, cur_i.blank, cur_i.quote_single);
          res0_o             = mk_res(KIND_BYTE, in_byte_i, 1'b0, 2'd0);
          push_cnt_o         = p.emit ? 2'd1 : 2'd0;
          nxt_o.mode         = p.mode;
          nxt_o.blank        = p.blank;
          nxt_o.quote_single = p.quote_single;
        end
      endcase
    end
    // Flag the final word of this item
    if (push_cnt_o == 2'd2) begin
      res1_o.last = 1'b1;
    end else if (push_cnt_o == 2'd1) begin
      res0_o.last = 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/rcs_outq.sv
// Result queue: takes up to two words per cycle, hands out one per pop.
`default_nettype none
module rcs_outq import rcs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  result_t          push0_i,
  input  result_t          push1_i,
  input  logic             pop_i,
  output result_t          head_o,
  output logic             head_valid_o,
  output logic [OQ_CW-1:0] count_o
);

  result_t          mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [OQ_CW-1:0] cnt_q, cnt_d;
  logic [OQ_AW-1:0] wr_next;

  assign wr_next = wr_q + OQ_AW'(1);

  // Advance pointers and fill level
  always_comb begin
    wr_d  = wr_q + OQ_AW'(push_cnt_i);
    rd_d  = rd_q + OQ_AW'(pop_i);
    cnt_d = cnt_q + OQ_CW'(push_cnt_i) - OQ_CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr_next] <= push1_i;
  end

  assign head_o       = mem_q[rd_q];
  assign head_valid_o = (cnt_q != '0);
  assign count_o      = cnt_q;

endmodule
`default_nettype wire
